@@ rtl/arlt_pkg.sv @@
// ============================================================================
// Address range lookup table package
// Shared sizes, operation codes and the types passed between the cells,
// the scan unit and the top level.
// ============================================================================
`default_nettype none

package arlt_pkg;

    // Table geometry.
    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int ADDR_W    = 64;
    localparam int OPC_W     = 3;
    localparam int OUT_IDX_W = 6;

    // Operation codes carried on the opcode field.
    localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OPC_W-1:0] OP_BY_ADDR   = 3'd1;
    localparam logic [OPC_W-1:0] OP_BY_UNWIND = 3'd2;
    localparam logic [OPC_W-1:0] OP_REBASE    = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR     = 3'd4;

    // One stored range.
    typedef struct packed {
        logic [ADDR_W-1:0] begin_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] unwind_addr;
    } t_entry;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic start;
        logic step;
        logic by_unwind;
    } t_scan_ctl;

    // Best candidate found so far by the scan unit.
    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_best;

endpackage

`default_nettype wire

@@ rtl/arlt_cell.sv @@
// ============================================================================
// Address range lookup table cell
// Holds one entry. It is loaded directly on an insert and otherwise takes
// its neighbor's entry whenever the ring rotates.
// ============================================================================
`default_nettype none

module arlt_cell
    import arlt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire t_entry i_shift_data,
    input  wire logic   i_write,
    input  wire t_entry i_write_data,
    output t_entry      o_entry
);

    t_entry r_entry;

    // A direct write wins over a rotation step; the two never coincide.
    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_entry <= i_write_data;
        end else if (i_shift) begin
            r_entry <= i_shift_data;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

@@ rtl/arlt_scan.sv @@
// ============================================================================
// Address range lookup table scan unit
// Watches the head cell of the ring while it rotates and keeps the best
// matching entry for either lookup kind.
// ============================================================================
`default_nettype none

module arlt_scan
    import arlt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_scan_ctl         i_ctl,
    input  wire t_entry            i_head,
    input  wire logic [IDX_W-1:0]  i_slot,
    input  wire logic              i_slot_valid,
    input  wire logic [ADDR_W-1:0] i_key,
    output t_best                  o_best
);

    logic             r_have;
    logic [IDX_W-1:0] r_idx;
    t_entry           r_entry;
    logic             w_addr_match;
    logic             w_unwind_match;
    logic             w_take;

    // Greatest nonzero begin not above the key; ties go to the later slot.
    assign w_addr_match = (i_head.begin_addr != '0) && (i_head.begin_addr <= i_key) &&
                          (!r_have || (i_head.begin_addr >= r_entry.begin_addr));

    // Exact unwind match; the later slot overrides an earlier one.
    assign w_unwind_match = (i_head.unwind_addr == i_key);

    assign w_take = i_ctl.step && i_slot_valid &&
                    (i_ctl.by_unwind ? w_unwind_match : w_addr_match);

    // Candidate flag is control state and is cleared on reset and on start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.start) begin
            r_have <= 1'b0;
        end else if (w_take) begin
            r_have <= 1'b1;
        end
    end

    // Candidate payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx   <= i_slot;
            r_entry <= i_head;
        end
    end

    assign o_best.have  = r_have;
    assign o_best.idx   = r_idx;
    assign o_best.entry = r_entry;

endmodule

`default_nettype wire

@@ rtl/address_range_lookup_table.sv @@
// Insert, clear and unused codes go from the idle state straight to the result
// state; lookups and rebase first rotate the whole ring in the scan state.
// One transaction at a time: the next is accepted only back in the idle state,
// after the result state has loaded the result register, and the result state
// waits while the previous result stalls.
// Reset (synchronous, active low) empties the table and drops any result.
// ============================================================================
// Address range lookup table
// Ring of entry cells with a scan unit at the head and a sequencer that
// handles insert, both lookups, rebase and clear.
// ============================================================================
`default_nettype none

module address_range_lookup_table
    import arlt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [OPC_W-1:0]     i_opcode,
    input  wire logic [ADDR_W-1:0]    i_lookup_address,
    input  wire logic [ADDR_W-1:0]    i_new_begin,
    input  wire logic [ADDR_W-1:0]    i_new_end,
    input  wire logic [ADDR_W-1:0]    i_new_unwind,
    input  wire logic [ADDR_W-1:0]    i_delta,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_found,
    output logic [OUT_IDX_W-1:0]      o_entry_index,
    output logic [ADDR_W-1:0]         o_hit_begin,
    output logic [ADDR_W-1:0]         o_hit_end,
    output logic [ADDR_W-1:0]         o_hit_unwind,
    output logic                      o_full_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic [OPC_W-1:0]  r_op;
    logic [ADDR_W-1:0] r_key;
    logic [ADDR_W-1:0] r_delta;
    logic [IDX_W-1:0]  r_ins_idx;
    logic              r_ins_full;

    t_entry            w_cell [ENTRIES];
    t_entry            w_wrap;
    t_entry            w_new;
    t_scan_ctl         w_ctl;
    t_best             w_best;
    logic              w_accept;
    logic              w_full;
    logic              w_ins_go;
    logic              w_scan;
    logic              w_slot_valid;
    logic              w_hit;
    logic              w_out_free;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_full       = (r_count == CNT_W'(ENTRIES));
    assign w_ins_go     = w_accept && (i_opcode == OP_INSERT) && !w_full;
    assign w_scan       = (r_state == S_SCAN);
    assign w_slot_valid = (r_k < r_count);
    assign w_out_free   = !o_valid || i_ready;

    assign w_new.begin_addr  = i_new_begin;
    assign w_new.end_addr    = i_new_end;
    assign w_new.unwind_addr = i_new_unwind;

    // Entry wrapping from the head to the tail; a rebase adds the delta here.
    always_comb begin
        w_wrap = w_cell[0];
        if ((r_op == OP_REBASE) && w_slot_valid) begin
            w_wrap.begin_addr  = w_cell[0].begin_addr + r_delta;
            w_wrap.end_addr    = w_cell[0].end_addr + r_delta;
            w_wrap.unwind_addr = w_cell[0].unwind_addr + r_delta;
        end
    end

    // Ring of cells; each takes the next one's entry while scanning.
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        t_entry w_sin;
        logic   w_wr;

        if (gi == ENTRIES - 1) begin : g_tail
            assign w_sin = w_wrap;
        end else begin : g_body
            assign w_sin = w_cell[gi + 1];
        end

        assign w_wr = w_ins_go && (r_count[IDX_W-1:0] == IDX_W'(gi));

        arlt_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_scan),
            .i_shift_data (w_sin),
            .i_write      (w_wr),
            .i_write_data (w_new),
            .o_entry      (w_cell[gi])
        );
    end

    // Scan unit watches the head cell.
    assign w_ctl.start     = w_accept;
    assign w_ctl.step      = w_scan && ((r_op == OP_BY_ADDR) || (r_op == OP_BY_UNWIND));
    assign w_ctl.by_unwind = (r_op == OP_BY_UNWIND);

    arlt_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_head       (w_cell[0]),
        .i_slot       (r_k[IDX_W-1:0]),
        .i_slot_valid (w_slot_valid),
        .i_key        (r_key),
        .o_best       (w_best)
    );

    // Hit decision after the scan has completed.
    always_comb begin
        case (r_op)
            OP_BY_ADDR:   w_hit = w_best.have && (r_key < w_best.entry.end_addr);
            OP_BY_UNWIND: w_hit = w_best.have && (r_key != '0);
            default:      w_hit = 1'b0;
        endcase
    end

    // Sequencer, table count and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    if (w_accept) begin
                        r_op       <= i_opcode;
                        r_key      <= i_lookup_address;
                        r_delta    <= i_delta;
                        r_ins_idx  <= r_count[IDX_W-1:0];
                        r_ins_full <= (i_opcode == OP_INSERT) && w_full;
                        r_k        <= '0;
                        if (w_ins_go) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_opcode == OP_CLEAR) begin
                            r_count <= '0;
                        end
                        if ((i_opcode == OP_BY_ADDR) || (i_opcode == OP_BY_UNWIND) ||
                            (i_opcode == OP_REBASE)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_SCAN: begin
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == CNT_W'(ENTRIES - 1)) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        o_valid       <= 1'b1;
                        o_found       <= w_hit;
                        o_full_res    <= r_ins_full;
                        o_entry_index <= '0;
                        o_hit_begin   <= '0;
                        o_hit_end     <= '0;
                        o_hit_unwind  <= '0;
                        if (w_hit) begin
                            o_entry_index <= OUT_IDX_W'(w_best.idx);
                            o_hit_begin   <= w_best.entry.begin_addr;
                            o_hit_end     <= w_best.entry.end_addr;
                            o_hit_unwind  <= w_best.entry.unwind_addr;
                        end else if ((r_op == OP_INSERT) && !r_ins_full) begin
                            o_entry_index <= OUT_IDX_W'(r_ins_idx);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The entry count never passes the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    // An insert into a table with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_go |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the entry count");

    // A lookup starts its scan at slot zero.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_opcode == OP_BY_ADDR) || (i_opcode == OP_BY_UNWIND)))
        |=> (w_scan && (r_k == '0)))
        else $error("lookup scan did not start at slot zero");

    // A hit and a dropped insert never share one result.
    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> !o_full_res)
        else $error("result flags both hit and full");

endmodule

`default_nettype wire

@@ test/address_range_lookup_table_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Address range lookup table testbench
// Drives inserts, both lookups, rebase, clear and unused codes through the
// request channel with random gaps, stalls the result channel at random, and
// checks every result field against a table predictor kept in the testbench.
// ============================================================================

module address_range_lookup_table_test;
    import arlt_pkg::*;

    localparam logic [ADDR_W-1:0] ALL_ONES   = '1;
    localparam int                RUN_ITEMS  = 900;
    localparam int                REPORT_CAP = 40;

    // One request transaction as queued for the driver.
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] stop_addr;
        logic [ADDR_W-1:0] unwind_addr;
        logic [ADDR_W-1:0] delta;
        logic              drain;
    } t_range_cmd;

    // One result transaction as predicted.
    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    hit_start;
        logic [ADDR_W-1:0]    hit_stop;
        logic [ADDR_W-1:0]    hit_unwind;
        logic                 full;
    } t_lookup_result;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic                 o_ready;
    logic [OPC_W-1:0]     i_opcode         = '0;
    logic [ADDR_W-1:0]    i_lookup_address = '0;
    logic [ADDR_W-1:0]    i_new_begin      = '0;
    logic [ADDR_W-1:0]    i_new_end        = '0;
    logic [ADDR_W-1:0]    i_new_unwind     = '0;
    logic [ADDR_W-1:0]    i_delta          = '0;
    logic                 o_valid;
    logic                 i_ready          = 1'b0;
    logic                 o_found;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic [ADDR_W-1:0]    o_hit_begin;
    logic [ADDR_W-1:0]    o_hit_end;
    logic [ADDR_W-1:0]    o_hit_unwind;
    logic                 o_full_res;

    address_range_lookup_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_lookup_address (i_lookup_address),
        .i_new_begin      (i_new_begin),
        .i_new_end        (i_new_end),
        .i_new_unwind     (i_new_unwind),
        .i_delta          (i_delta),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_entry_index    (o_entry_index),
        .o_hit_begin      (o_hit_begin),
        .o_hit_end        (o_hit_end),
        .o_hit_unwind     (o_hit_unwind),
        .o_full_res       (o_full_res)
    );

    // Clock and the single reset pulse at the start of the run.
    always #2 i_clk = ~i_clk;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    t_range_cmd     pending_q[$];
    t_lookup_result expected_q[$];
    int             sent_count   = 0;
    int             result_count = 0;
    int             fail_count   = 0;
    int             gap_left     = 0;
    int             burst_left   = 0;
    int             stall_left   = 0;
    int             quiet_left   = 0;

    // Run limit, several times the slowest correct run.
    initial begin
        #4_000_000;
        $display("Timeout at %0t with %0d results outstanding.", $time,
                 sent_count - result_count);
        $display("TEST FAILED");
        $finish;
    end

    // Predicted table contents and run statistics.
    logic [ADDR_W-1:0] tbl_start  [ENTRIES];
    logic [ADDR_W-1:0] tbl_stop   [ENTRIES];
    logic [ADDR_W-1:0] tbl_unwind [ENTRIES];
    int                tbl_count = 0;
    int n_insert = 0, n_dropped = 0, n_addr_hit = 0, n_addr_miss = 0;
    int n_unwind_hit = 0, n_unwind_miss = 0, n_rebase = 0, n_clear = 0;

    // Table shadow used only while building stimulus, to aim lookups.
    logic [ADDR_W-1:0] gen_start  [ENTRIES];
    logic [ADDR_W-1:0] gen_stop   [ENTRIES];
    logic [ADDR_W-1:0] gen_unwind [ENTRIES];
    int                gen_count  = 0;
    int                body_count = 0;
    logic              drain_next = 1'b0;
    logic [ADDR_W-1:0] region_base;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Work out the result of one accepted transaction and update the table.
    task automatic predict_result(input t_range_cmd c);
        t_lookup_result res;
        logic           have;
        int             best;
        res  = '0;
        have = 1'b0;
        best = 0;
        case (c.opcode)
            OP_INSERT: begin
                if (tbl_count >= ENTRIES) begin
                    res.full = 1'b1;
                    n_dropped++;
                end else begin
                    tbl_start[tbl_count]  = c.start_addr;
                    tbl_stop[tbl_count]   = c.stop_addr;
                    tbl_unwind[tbl_count] = c.unwind_addr;
                    res.index = OUT_IDX_W'(tbl_count);
                    tbl_count++;
                    n_insert++;
                end
            end
            OP_BY_ADDR: begin
                // Greatest nonzero start not above the address; ties go to
                // the latest slot.
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_start[i] != '0 && tbl_start[i] <= c.address &&
                        (!have || tbl_start[i] >= tbl_start[best])) begin
                        have = 1'b1;
                        best = i;
                    end
                end
                have = have && (c.address < tbl_stop[best]);
                if (have) n_addr_hit++;
                else n_addr_miss++;
            end
            OP_BY_UNWIND: begin
                if (c.address != '0) begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_unwind[i] == c.address) begin
                            have = 1'b1;
                            best = i;
                        end
                    end
                end
                if (have) n_unwind_hit++;
                else n_unwind_miss++;
            end
            OP_REBASE: begin
                for (int i = 0; i < tbl_count; i++) begin
                    tbl_start[i]  = tbl_start[i] + c.delta;
                    tbl_stop[i]   = tbl_stop[i] + c.delta;
                    tbl_unwind[i] = tbl_unwind[i] + c.delta;
                end
                n_rebase++;
            end
            OP_CLEAR: begin
                tbl_count = 0;
                n_clear++;
            end
            default: begin
            end
        endcase
        if (have) begin
            res.found      = 1'b1;
            res.index      = OUT_IDX_W'(best);
            res.hit_start  = tbl_start[best];
            res.hit_stop   = tbl_stop[best];
            res.hit_unwind = tbl_unwind[best];
        end
        expected_q.push_back(res);
    endtask

    // Queue a transaction and keep the stimulus shadow in step.
    task automatic push_cmd(input t_range_cmd c);
        c.drain    = drain_next;
        drain_next = 1'b0;
        case (c.opcode)
            OP_INSERT: begin
                if (gen_count < ENTRIES) begin
                    gen_start[gen_count]  = c.start_addr;
                    gen_stop[gen_count]   = c.stop_addr;
                    gen_unwind[gen_count] = c.unwind_addr;
                    gen_count++;
                end
            end
            OP_REBASE: begin
                for (int i = 0; i < gen_count; i++) begin
                    gen_start[i]  = gen_start[i] + c.delta;
                    gen_stop[i]   = gen_stop[i] + c.delta;
                    gen_unwind[i] = gen_unwind[i] + c.delta;
                end
            end
            OP_CLEAR: gen_count = 0;
            default: begin
            end
        endcase
        if (c.opcode <= OP_CLEAR) body_count++;
        pending_q.push_back(c);
    endtask

    // Fields that an operation ignores carry random values.
    function automatic t_range_cmd random_cmd(input logic [OPC_W-1:0] op);
        t_range_cmd c;
        c.opcode      = op;
        c.address     = rand64();
        c.start_addr  = rand64();
        c.stop_addr   = rand64();
        c.unwind_addr = rand64();
        c.delta       = rand64();
        c.drain       = 1'b0;
        return c;
    endfunction

    task automatic add_insert(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] e,
                              input logic [ADDR_W-1:0] u);
        t_range_cmd c;
        c             = random_cmd(OP_INSERT);
        c.start_addr  = s;
        c.stop_addr   = e;
        c.unwind_addr = u;
        push_cmd(c);
    endtask

    task automatic add_lookup(input logic [OPC_W-1:0] op, input logic [ADDR_W-1:0] a);
        t_range_cmd c;
        c         = random_cmd(op);
        c.address = a;
        push_cmd(c);
    endtask

    task automatic add_rebase(input logic [ADDR_W-1:0] d);
        t_range_cmd c;
        c       = random_cmd(OP_REBASE);
        c.delta = d;
        push_cmd(c);
    endtask

    task automatic add_plain(input logic [OPC_W-1:0] op);
        push_cmd(random_cmd(op));
    endtask

    // Random insert, mostly clustered in the current region so lookups meet.
    task automatic add_random_insert();
        logic [ADDR_W-1:0] s, e, u;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 5) s = '0;
        else if (r < 15 && gen_count > 0) s = gen_start[$urandom_range(0, gen_count - 1)];
        else if (r < 22) s = rand64();
        else s = region_base + {$urandom_range(0, 4095), 4'h0};
        r = $urandom_range(0, 99);
        if (r < 6) e = s - $urandom_range(0, 16);
        else if (r < 10) e = rand64();
        else e = s + $urandom_range(1, 8192);
        r = $urandom_range(0, 99);
        if (r < 5) u = '0;
        else if (r < 15 && gen_count > 0) u = gen_unwind[$urandom_range(0, gen_count - 1)];
        else u = rand64();
        add_insert(s, e, u);
    endtask

    // Lookup address aimed near stored ranges most of the time.
    task automatic add_random_lookup(input logic [OPC_W-1:0] op);
        logic [ADDR_W-1:0] a;
        int                j;
        int                r;
        r = $urandom_range(0, 99);
        j = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
        if (gen_count == 0 || r >= 80) begin
            a = (r < 84) ? '0 : (r < 88) ? ALL_ONES : rand64();
        end else if (op == OP_BY_UNWIND) begin
            a = (r < 70) ? gen_unwind[j] : gen_unwind[j] + 1;
        end else begin
            case (r % 5)
                0: a = gen_start[j] + $urandom_range(0, 64);
                1: a = gen_stop[j] - 1;
                2: a = gen_stop[j];
                3: a = gen_start[j] - 1;
                default: a = gen_start[j];
            endcase
        end
        add_lookup(op, a);
    endtask

    task automatic add_random_rebase();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12 && gen_count > 0) begin
            // Shift one entry's start or unwind address onto zero.
            if (r < 6) add_rebase(ADDR_W'(0) - gen_start[$urandom_range(0, gen_count - 1)]);
            else add_rebase(ADDR_W'(0) - gen_unwind[$urandom_range(0, gen_count - 1)]);
        end else if (r < 55) begin
            add_rebase(rand64());
        end else begin
            add_rebase((r & 1) ? ADDR_W'($urandom_range(0, 65535))
                               : ADDR_W'(0) - $urandom_range(0, 65535));
        end
        region_base = region_base + pending_q[$].delta;
    endtask

    task automatic add_unused();
        add_plain(OP_CLEAR + OPC_W'($urandom_range(1, 3)));
    endtask

    // Fill the table past its capacity, with lookups along the way.
    task automatic fill_episode();
        add_plain(OP_CLEAR);
        region_base = rand64();
        for (int i = 0; i < ENTRIES + 6; i++) begin
            add_random_insert();
            if ($urandom_range(0, 7) == 0) add_random_lookup(OP_BY_ADDR);
        end
        repeat (6) add_random_lookup(OP_BY_ADDR);
        repeat (3) add_random_lookup(OP_BY_UNWIND);
        add_random_rebase();
        repeat (4) add_random_lookup(OP_BY_ADDR);
        add_random_lookup(OP_BY_UNWIND);
    endtask

    task automatic mixed_episode();
        int r;
        if ($urandom_range(0, 1) == 0) begin
            add_plain(OP_CLEAR);
            region_base = rand64();
        end
        repeat ($urandom_range(8, 40)) begin
            r = $urandom_range(0, 99);
            drain_next = ($urandom_range(0, 99) < 2);
            if (r < 32) add_random_insert();
            else if (r < 62) add_random_lookup(OP_BY_ADDR);
            else if (r < 80) add_random_lookup(OP_BY_UNWIND);
            else if (r < 88) add_random_rebase();
            else if (r < 91) add_plain(OP_CLEAR);
            else if (r < 95) add_unused();
            else add_insert(rand64(), rand64(), rand64());
        end
    endtask

    // Stimulus, then wait for the last results and report.
    initial begin
        int fills;
        fills = 0;

        // Directed part: empty table, ties, range edges, wrap on rebase.
        add_lookup(OP_BY_ADDR, 64'h1200);
        add_lookup(OP_BY_UNWIND, 64'hAAA0);
        add_insert('0, ALL_ONES, '0);
        add_insert(64'h1000, 64'h2000, 64'hAAA0);
        add_insert(64'h1000, 64'h1500, 64'hAAA0);
        add_insert(ALL_ONES, ALL_ONES, ALL_ONES);
        add_lookup(OP_BY_ADDR, 64'h1200);
        add_lookup(OP_BY_ADDR, 64'h1600);
        add_lookup(OP_BY_ADDR, 64'h0FFF);
        add_lookup(OP_BY_ADDR, '0);
        add_lookup(OP_BY_ADDR, ALL_ONES);
        add_lookup(OP_BY_UNWIND, '0);
        add_lookup(OP_BY_UNWIND, 64'hAAA0);
        drain_next = 1'b1;
        add_lookup(OP_BY_UNWIND, ALL_ONES);
        add_rebase(ALL_ONES);
        add_rebase(64'h1);
        add_lookup(OP_BY_ADDR, 64'h1000);
        add_plain(OP_CLEAR + 3'd1);
        add_plain(OP_CLEAR + 3'd2);
        add_plain(OP_CLEAR + 3'd3);
        add_plain(OP_CLEAR);
        add_lookup(OP_BY_ADDR, 64'h1200);
        add_insert(64'h1, ALL_ONES, 64'h1);
        add_lookup(OP_BY_ADDR, ALL_ONES - 1);
        add_lookup(OP_BY_UNWIND, 64'h1);

        // Random part: a few full-table episodes among mixed sequences.
        body_count = 0;
        while (body_count < RUN_ITEMS) begin
            if (fills == 0 || (fills < 3 && $urandom_range(0, 99) < 6)) begin
                fill_episode();
                fills++;
            end else begin
                mixed_episode();
            end
        end

        while (pending_q.size() != 0 || i_valid) @(posedge i_clk);
        while (result_count < sent_count) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts, %0d dropped on a full table, %0d rebases, %0d clears.",
                 result_count, n_insert, n_dropped, n_rebase, n_clear);
        $display("Address lookups %0d hit / %0d missed; unwind lookups %0d hit / %0d missed.",
                 n_addr_hit, n_addr_miss, n_unwind_hit, n_unwind_miss);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Gap after a request: mostly none or short, a few long, some bursts.
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) burst_left = $urandom_range(20, 60);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver. A transaction marked for draining waits until every
    // earlier result has come back.
    always @(posedge i_clk) begin
        t_range_cmd nxt;
        t_range_cmd seen;
        int         done_after;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            done_after = sent_count;
            if (i_valid && o_ready) begin
                seen.opcode      = i_opcode;
                seen.address     = i_lookup_address;
                seen.start_addr  = i_new_begin;
                seen.stop_addr   = i_new_end;
                seen.unwind_addr = i_new_unwind;
                seen.delta       = i_delta;
                seen.drain       = 1'b0;
                predict_result(seen);
                done_after = sent_count + 1;
                sent_count <= done_after;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain && result_count != done_after)) begin
                    nxt = pending_q.pop_front();
                    i_opcode         <= nxt.opcode;
                    i_lookup_address <= nxt.address;
                    i_new_begin      <= nxt.start_addr;
                    i_new_end        <= nxt.stop_addr;
                    i_new_unwind     <= nxt.unwind_addr;
                    i_delta          <= nxt.delta;
                    i_valid          <= 1'b1;
                    gap_left         <= next_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Stall length for the result channel, with quiet stretches.
    function automatic int next_stall();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) quiet_left = $urandom_range(100, 400);
        else if (r < 14) return $urandom_range(1, 3);
        else if (r < 16) return $urandom_range(10, 60);
        return 0;
    endfunction

    // Result monitor: compares each result transaction with the oldest
    // prediction and drives the result-side ready.
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t: unexpected result, expected none, actual found=%b index=%0d",
                                 $time, o_found, o_entry_index);
                end else begin
                    want = expected_q.pop_front();
                    check_field("found", ADDR_W'(want.found), ADDR_W'(o_found));
                    check_field("entry_index", ADDR_W'(want.index), ADDR_W'(o_entry_index));
                    check_field("hit_begin", want.hit_start, o_hit_begin);
                    check_field("hit_end", want.hit_stop, o_hit_end);
                    check_field("hit_unwind", want.hit_unwind, o_hit_unwind);
                    check_field("full_res", ADDR_W'(want.full), ADDR_W'(o_full_res));
                end
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= next_stall();
            end
        end
    end

endmodule
